// ===== hw/rtl/ghsp_pkg.sv =====
// Shared types, constants and the exponential lookup table for the
// Gaussian splat histogram. No dependencies; imported by every module.
package ghsp_pkg;

   // Histogram geometry
   localparam int MAX_BINS_X      = 64;
   localparam int MAX_BINS_Y      = 64;
   localparam int BIN_DEPTH       = MAX_BINS_X * MAX_BINS_Y;
   localparam int ADDR_W          = $clog2(BIN_DEPTH);

   // Exponential table: entry n holds exp(-16*n/DEPTH) in Q32
   localparam int EXP_TABLE_DEPTH = 256;
   localparam int EXP_IDX_W       = $clog2(EXP_TABLE_DEPTH);
   localparam int EXP_W           = 33;
   localparam int EXP_RANGE_SHIFT = 36;   // 16.0 in Q32

   // Distance in sigmas, Q5.16, saturated at 16.0
   localparam int K_W             = 21;
   localparam logic [K_W-1:0] KMAX_Q16 = 21'h10_0000;
   localparam int E_W             = 42;

   // Shared divider
   localparam int DIVN_W          = 56;
   localparam int DIVD_W          = 62;

   // Commands
   localparam logic [1:0] CMD_SPLAT  = 2'd0;
   localparam logic [1:0] CMD_CLEAR  = 2'd1;
   localparam logic [1:0] CMD_REPORT = 2'd2;
   localparam logic [1:0] CMD_NONE   = 2'd3;

   // Register indexes
   localparam int CSR_IDX_W = 3;
   localparam logic [CSR_IDX_W-1:0] CSR_ORIGIN_X    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ORIGIN_Y    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_BIN_WIDTH_X = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_BIN_WIDTH_Y = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_BINS_X      = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_BINS_Y      = 3'd5;

   typedef struct packed {
      logic [1:0]         command;
      logic signed [31:0] point_x;
      logic signed [31:0] point_y;
      logic [30:0]        spread_x;
      logic [30:0]        spread_y;
   } req_item_type;

   typedef struct packed {
      logic [12:0]        bins_updated;
      logic [5:0]         peak_ix;
      logic [5:0]         peak_iy;
      logic [31:0]        peak_content;
      logic signed [31:0] peak_x;
      logic signed [31:0] peak_y;
   } rsp_item_type;

   typedef struct packed {
      logic              start;
      logic [DIVN_W-1:0] dividend;
      logic [DIVD_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic              done;
      logic [DIVN_W-1:0] quotient;
   } div_rsp_type;

   typedef logic [EXP_W-1:0] exp_tab_type [EXP_TABLE_DEPTH];

   // Build the table at elaboration: series for the step ratio, then
   // repeated rounded multiplication
   function automatic exp_tab_type build_exp_table();
      exp_tab_type     tab;
      longint unsigned h;
      longint unsigned term;
      longint unsigned pos;
      longint unsigned neg;
      longint unsigned r;
      h    = (64'd16 << 32) / EXP_TABLE_DEPTH;
      term = 64'd1 << 32;
      pos  = term;
      neg  = 64'd0;
      for (int k = 1; k <= 24; k++) begin
         term = (term * h) / 64'(k);
         if ((k & 1) == 1) neg += term;
         else pos += term;
      end
      r = pos - neg;
      tab[0] = EXP_W'(64'd1 << 32);
      for (int n = 1; n < EXP_TABLE_DEPTH; n++) begin
         tab[n] = EXP_W'((64'(tab[n-1]) * r + (64'd1 << 31)) >> 32);
      end
      return tab;
   endfunction

   localparam exp_tab_type EXP_TAB = build_exp_table();

endpackage

// ===== hw/rtl/ghsp_divider.sv =====
// Restoring divider, one quotient bit per cycle, shared by all divisions
// of the splat. Depends on ghsp_pkg.
module ghsp_divider (
   input  logic                 clock,
   input  logic                 reset,
   input  ghsp_pkg::div_req_type div_req,
   output ghsp_pkg::div_rsp_type div_rsp
);
   import ghsp_pkg::*;

   localparam int CNT_W = $clog2(DIVN_W);

   logic [DIVD_W:0]   rem_ff, rem_in;
   logic [DIVN_W-1:0] quo_ff, quo_in;
   logic [DIVD_W-1:0] den_ff;
   logic [CNT_W-1:0]  cnt_ff;
   logic              run_ff;
   logic              done_ff;
   logic [DIVD_W:0]   shifted;
   logic [DIVD_W:0]   diff;

   // One restoring step: shift in the next dividend bit, subtract if it fits
   always_comb begin
      shifted = {rem_ff[DIVD_W-1:0], quo_ff[DIVN_W-1]};
      diff    = shifted - {1'b0, den_ff};
      if (shifted >= {1'b0, den_ff}) begin
         rem_in = diff;
         quo_in = {quo_ff[DIVN_W-2:0], 1'b1};
      end else begin
         rem_in = shifted;
         quo_in = {quo_ff[DIVN_W-2:0], 1'b0};
      end
   end

   // Load operands or advance one step
   always_ff @(posedge clock) begin
      if (div_req.start) begin
         rem_ff <= '0;
         quo_ff <= div_req.dividend;
         den_ff <= div_req.divisor;
      end else if (run_ff) begin
         rem_ff <= rem_in;
         quo_ff <= quo_in;
      end
   end

   // Step counter and completion flag
   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= run_ff && !div_req.start && (cnt_ff == CNT_W'(DIVN_W - 1));
         if (div_req.start) begin
            run_ff <= 1'b1;
            cnt_ff <= '0;
         end else if (run_ff) begin
            if (cnt_ff == CNT_W'(DIVN_W - 1)) begin
               run_ff <= 1'b0;
            end else begin
               cnt_ff <= cnt_ff + CNT_W'(1);
            end
         end
      end
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quo_ff;

endmodule

// ===== hw/rtl/gaussian_histogram_splat_peak.sv =====
// Top level of the Gaussian splat histogram: configuration registers, bin
// memory, command sequencer and peak scan. Depends on ghsp_pkg, ghsp_divider.
//
// Usage: raise start with a command beat on req_item while busy is low; the
// beat is taken at that edge and busy rises. Every command gives one result
// beat on rsp_item, marked by rsp_strobe for a single cycle; it cannot be
// held off, so capture it when it appears. Registers are written through
// csr_we/csr_index/csr_wdata while busy is low.
// What each command costs is set by the shared one-bit-per-cycle divider and
// the single memory port:
//   splat  : four window-bound divisions, one per column and one or two per bin
//   clear  : all 4096 bins, one bin written per cycle
//   report : every bin in use, one bin read per cycle
//   command 3 : result of zeros
// One command is in flight at a time; busy falls in the cycle that the
// result strobe is shown, so the next command may start in that cycle.
// Reset: registers take their defaults and the memory is swept to zero,
// which holds busy high after reset is released until every bin is cleared.
module gaussian_histogram_splat_peak (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  ghsp_pkg::req_item_type         req_item,
   output logic                           rsp_strobe,
   output ghsp_pkg::rsp_item_type         rsp_item,
   input  logic                           csr_we,
   input  logic [ghsp_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [31:0]                    csr_wdata
);
   import ghsp_pkg::*;

   localparam logic [4:0] ST_INIT      = 5'd0;
   localparam logic [4:0] ST_IDLE      = 5'd1;
   localparam logic [4:0] ST_SWEEP     = 5'd2;
   localparam logic [4:0] ST_WIN_PREP  = 5'd3;
   localparam logic [4:0] ST_WIN_DIV   = 5'd4;
   localparam logic [4:0] ST_WIN_CHECK = 5'd5;
   localparam logic [4:0] ST_COL_PREP  = 5'd6;
   localparam logic [4:0] ST_COL_DIV   = 5'd7;
   localparam logic [4:0] ST_ROW_PREP  = 5'd8;
   localparam logic [4:0] ST_ROW_DIV   = 5'd9;
   localparam logic [4:0] ST_SQUARE    = 5'd10;
   localparam logic [4:0] ST_WEIGHT    = 5'd11;
   localparam logic [4:0] ST_WT_DIV    = 5'd12;
   localparam logic [4:0] ST_WRITE     = 5'd13;
   localparam logic [4:0] ST_SCAN      = 5'd14;
   localparam logic [4:0] ST_SCAN_LAST = 5'd15;
   localparam logic [4:0] ST_RESP      = 5'd16;

   // Configuration registers
   logic signed [31:0] origin_x_ff, origin_y_ff;
   logic [30:0]        bin_width_x_ff, bin_width_y_ff;
   logic [6:0]         bins_x_ff, bins_y_ff;

   // Sequencer
   logic [4:0]         state_ff, state_in;
   logic [ADDR_W-1:0]  sweep_ff;
   logic               div_go_ff;
   logic               tag_v_ff;
   logic               rsp_strobe_ff;
   rsp_item_type       rsp_item_ff, rsp_next;

   // Command context
   logic [1:0]         cmd_ff;
   logic signed [32:0] dx_ff, dy_ff;
   logic [30:0]        sx_ff, sy_ff;
   logic [61:0]        sxy_ff;
   logic [1:0]         win_sel_ff;
   logic [6:0]         xl_ff, xh_ff, yl_ff, yh_ff;
   logic [6:0]         i_ff, j_ff;
   logic [K_W-1:0]     kx_ff, ky_ff;
   logic [E_W-1:0]     e_ff;
   logic [31:0]        w_ff;
   logic [ADDR_W-1:0]  addr_ff;
   logic [12:0]        count_ff;
   logic               neg_ff;
   logic [DIVN_W-1:0]  div_num_ff;
   logic [DIVD_W-1:0]  div_den_ff;
   logic [31:0]        best_ff;
   logic [6:0]         bi_ff, bj_ff, tag_i_ff, tag_j_ff;

   // Bin memory
   logic [31:0]        bin_mem [BIN_DEPTH];
   logic [31:0]        rd_data_ff;
   logic               mem_we, mem_re;
   logic [ADDR_W-1:0]  mem_waddr;
   logic [31:0]        mem_wdata;

   // Datapath nets
   div_req_type        div_req;
   div_rsp_type        div_rsp;
   logic [6:0]         nx, ny;
   logic [14:0]        addr_full;
   logic [ADDR_W-1:0]  bin_addr;
   logic               sweep_last;
   logic signed [32:0] win_d;
   logic [30:0]        win_s, win_w;
   logic               win_up;
   logic signed [39:0] win_dx, win_s4, win_we, win_num;
   logic [39:0]        win_mag;
   logic               k_row;
   logic signed [32:0] k_d;
   logic [6:0]         k_idx;
   logic [30:0]        k_w, k_s;
   logic [38:0]        k_prod;
   logic signed [40:0] k_num;
   logic [40:0]        k_abs;
   logic [K_W-1:0]     k_sat;
   logic [E_W:0]       e_sum;
   logic [63:0]        n_full;
   logic               n_ok;
   logic [31:0]        w_sat;
   logic [32:0]        bin_sum;
   logic               row_last, col_last, scan_row_last, scan_col_last;
   logic [38:0]        cx_prod, cy_prod;
   logic signed [39:0] cx_full, cy_full;

   function automatic logic [6:0] eff_count(logic [6:0] v, int max_bins);
      logic [6:0] r;
      if (v == 7'd0) r = 7'd1;
      else if (32'(v) > max_bins) r = 7'(max_bins);
      else r = v;
      return r;
   endfunction

   function automatic logic [6:0] clamp_q(logic [DIVN_W-1:0] q, logic [6:0] lim);
      logic [6:0] r;
      if (q > DIVN_W'(lim)) r = lim;
      else r = q[6:0];
      return r;
   endfunction

   function automatic logic signed [31:0] sat32(logic signed [39:0] v);
      logic signed [31:0] r;
      if (v > 40'sd2147483647) r = 32'sh7FFF_FFFF;
      else if (v < -40'sd2147483648) r = 32'sh8000_0000;
      else r = v[31:0];
      return r;
   endfunction

   // Write configuration registers; zero widths read as the smallest step
   always_ff @(posedge clock) begin
      if (reset) begin
         origin_x_ff    <= '0;
         origin_y_ff    <= '0;
         bin_width_x_ff <= 31'd65536;
         bin_width_y_ff <= 31'd65536;
         bins_x_ff      <= 7'd64;
         bins_y_ff      <= 7'd64;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_ORIGIN_X: origin_x_ff <= csr_wdata;
            CSR_ORIGIN_Y: origin_y_ff <= csr_wdata;
            CSR_BIN_WIDTH_X:
               bin_width_x_ff <= (csr_wdata[30:0] == '0) ? 31'd1 : csr_wdata[30:0];
            CSR_BIN_WIDTH_Y:
               bin_width_y_ff <= (csr_wdata[30:0] == '0) ? 31'd1 : csr_wdata[30:0];
            CSR_BINS_X: bins_x_ff <= csr_wdata[6:0];
            CSR_BINS_Y: bins_y_ff <= csr_wdata[6:0];
            default: ;
         endcase
      end
   end

   assign nx = eff_count(bins_x_ff, MAX_BINS_X);
   assign ny = eff_count(bins_y_ff, MAX_BINS_Y);

   // Bin address of the current column and row
   assign addr_full  = 15'(i_ff) + 15'(j_ff) * 15'(nx);
   assign bin_addr   = addr_full[ADDR_W-1:0];
   assign sweep_last = (sweep_ff == ADDR_W'(BIN_DEPTH - 1));

   // Window bound numerator: 2*(d -+ 4*sigma) -+ w
   always_comb begin
      case (win_sel_ff)
         2'd0: begin win_d = dx_ff; win_s = sx_ff; win_w = bin_width_x_ff; win_up = 1'b0; end
         2'd1: begin win_d = dx_ff; win_s = sx_ff; win_w = bin_width_x_ff; win_up = 1'b1; end
         2'd2: begin win_d = dy_ff; win_s = sy_ff; win_w = bin_width_y_ff; win_up = 1'b0; end
         default: begin
            win_d = dy_ff; win_s = sy_ff; win_w = bin_width_y_ff; win_up = 1'b1;
         end
      endcase
      win_dx = 40'(win_d);
      win_s4 = signed'({7'b0, win_s, 2'b00});
      win_we = signed'({9'b0, win_w});
      if (win_up) win_num = ((win_dx + win_s4) <<< 1) + win_we;
      else win_num = ((win_dx - win_s4) <<< 1) - win_we;
      win_mag = (win_num < 0) ? 40'(-win_num) : 40'(win_num);
   end

   // Centre distance numerator: 2*d - (2*idx+1)*w, for a column or a row
   always_comb begin
      k_row = (state_ff == ST_ROW_PREP);
      k_d   = k_row ? dy_ff : dx_ff;
      k_idx = k_row ? j_ff : i_ff;
      k_w   = k_row ? bin_width_y_ff : bin_width_x_ff;
      k_s   = k_row ? sy_ff : sx_ff;
      k_prod = 39'({k_idx, 1'b1}) * 39'(k_w);
      k_num  = (41'(k_d) <<< 1) - signed'({2'b0, k_prod});
      k_abs  = (k_num < 0) ? 41'(-k_num) : 41'(k_num);
   end

   assign k_sat = (div_rsp.quotient > DIVN_W'(KMAX_Q16)) ? KMAX_Q16
                                                       : div_rsp.quotient[K_W-1:0];

   // Exponent and table index
   assign e_sum  = (E_W+1)'(kx_ff) * (E_W+1)'(kx_ff) + (E_W+1)'(ky_ff) * (E_W+1)'(ky_ff);
   assign n_full = (64'(e_ff) * 64'(EXP_TABLE_DEPTH)) >> EXP_RANGE_SHIFT;
   assign n_ok   = (n_full < 64'(EXP_TABLE_DEPTH));

   // Weight and bin sum, both saturating
   assign w_sat   = (div_rsp.quotient[DIVN_W-1:32] != '0) ? 32'hFFFF_FFFF
                                                         : div_rsp.quotient[31:0];
   assign bin_sum = {1'b0, rd_data_ff} + {1'b0, w_ff};

   assign row_last      = ((j_ff + 7'd1) == yh_ff);
   assign col_last      = ((i_ff + 7'd1) == xh_ff);
   assign scan_row_last = ((j_ff + 7'd1) == ny);
   assign scan_col_last = ((i_ff + 7'd1) == nx);

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_INIT:  if (sweep_last) state_in = ST_IDLE;
         ST_SWEEP: if (sweep_last) state_in = ST_RESP;
         ST_IDLE: begin
            if (start) begin
               case (req_item.command)
                  CMD_SPLAT:  state_in = ST_WIN_PREP;
                  CMD_CLEAR:  state_in = ST_SWEEP;
                  CMD_REPORT: state_in = ST_SCAN;
                  default:    state_in = ST_RESP;
               endcase
            end
         end
         ST_WIN_PREP: state_in = ST_WIN_DIV;
         ST_WIN_DIV: begin
            if (div_rsp.done) state_in = (win_sel_ff == 2'd3) ? ST_WIN_CHECK : ST_WIN_PREP;
         end
         ST_WIN_CHECK: begin
            state_in = ((xl_ff < xh_ff) && (yl_ff < yh_ff)) ? ST_COL_PREP : ST_RESP;
         end
         ST_COL_PREP: state_in = ST_COL_DIV;
         ST_COL_DIV:  if (div_rsp.done) state_in = ST_ROW_PREP;
         ST_ROW_PREP: state_in = ST_ROW_DIV;
         ST_ROW_DIV:  if (div_rsp.done) state_in = ST_SQUARE;
         ST_SQUARE:   state_in = ST_WEIGHT;
         ST_WEIGHT:   state_in = n_ok ? ST_WT_DIV : ST_WRITE;
         ST_WT_DIV:   if (div_rsp.done) state_in = ST_WRITE;
         ST_WRITE: begin
            if (!row_last) state_in = ST_ROW_PREP;
            else if (!col_last) state_in = ST_COL_PREP;
            else state_in = ST_RESP;
         end
         ST_SCAN:      if (scan_row_last && scan_col_last) state_in = ST_SCAN_LAST;
         ST_SCAN_LAST: state_in = ST_RESP;
         ST_RESP:      state_in = ST_IDLE;
         default:      state_in = ST_IDLE;
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_INIT;
         sweep_ff      <= '0;
         div_go_ff     <= 1'b0;
         tag_v_ff      <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         sweep_ff      <= (state_ff == ST_INIT || state_ff == ST_SWEEP)
                          ? sweep_ff + ADDR_W'(1) : '0;
         div_go_ff     <= (state_ff == ST_WIN_PREP) || (state_ff == ST_COL_PREP)
                          || (state_ff == ST_ROW_PREP) || (state_ff == ST_WEIGHT && n_ok);
         tag_v_ff      <= (state_ff == ST_SCAN);
         rsp_strobe_ff <= (state_ff == ST_RESP);
      end
   end

   // Spread product for the weight divisor
   always_ff @(posedge clock) begin
      sxy_ff <= 62'(sx_ff) * 62'(sy_ff);
   end

   // Command context, divider operands and peak tracking
   always_ff @(posedge clock) begin
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd_ff     <= req_item.command;
               dx_ff      <= 33'(req_item.point_x) - 33'(origin_x_ff);
               dy_ff      <= 33'(req_item.point_y) - 33'(origin_y_ff);
               sx_ff      <= (req_item.spread_x == '0) ? 31'd1 : req_item.spread_x;
               sy_ff      <= (req_item.spread_y == '0) ? 31'd1 : req_item.spread_y;
               count_ff   <= '0;
               win_sel_ff <= '0;
               best_ff    <= '0;
               bi_ff      <= '0;
               bj_ff      <= '0;
               i_ff       <= '0;
               j_ff       <= '0;
            end
         end
         ST_WIN_PREP: begin
            div_num_ff <= DIVN_W'(win_mag);
            div_den_ff <= DIVD_W'({win_w, 1'b0});
            neg_ff     <= (win_num < 0);
         end
         ST_WIN_DIV: begin
            if (div_rsp.done) begin
               case (win_sel_ff)
                  2'd0: xl_ff <= neg_ff ? 7'd0 : clamp_q(div_rsp.quotient, nx);
                  2'd1: xh_ff <= neg_ff ? 7'd0 : clamp_q(div_rsp.quotient, nx);
                  2'd2: yl_ff <= neg_ff ? 7'd0 : clamp_q(div_rsp.quotient, ny);
                  default: yh_ff <= neg_ff ? 7'd0 : clamp_q(div_rsp.quotient, ny);
               endcase
               win_sel_ff <= win_sel_ff + 2'd1;
            end
         end
         ST_WIN_CHECK: i_ff <= xl_ff;
         ST_COL_PREP: begin
            div_num_ff <= {k_abs[39:0], 16'b0};
            div_den_ff <= DIVD_W'({k_s, 1'b0});
            j_ff       <= yl_ff;
         end
         ST_COL_DIV: if (div_rsp.done) kx_ff <= k_sat;
         ST_ROW_PREP: begin
            div_num_ff <= {k_abs[39:0], 16'b0};
            div_den_ff <= DIVD_W'({k_s, 1'b0});
         end
         ST_ROW_DIV: if (div_rsp.done) ky_ff <= k_sat;
         ST_SQUARE: begin
            e_ff    <= e_sum[E_W:1];
            addr_ff <= bin_addr;
         end
         ST_WEIGHT: begin
            div_num_ff <= DIVN_W'({EXP_TAB[n_full[EXP_IDX_W-1:0]], 16'b0});
            div_den_ff <= sxy_ff;
            w_ff       <= '0;
         end
         ST_WT_DIV: if (div_rsp.done) w_ff <= w_sat;
         ST_WRITE: begin
            count_ff <= count_ff + 13'd1;
            if (!row_last) j_ff <= j_ff + 7'd1;
            else if (!col_last) i_ff <= i_ff + 7'd1;
         end
         ST_SCAN: begin
            tag_i_ff <= i_ff;
            tag_j_ff <= j_ff;
            if (scan_row_last) begin
               j_ff <= '0;
               i_ff <= i_ff + 7'd1;
            end else begin
               j_ff <= j_ff + 7'd1;
            end
         end
         ST_RESP: rsp_item_ff <= rsp_next;
         default: ;
      endcase
      // Keep the first strictly greatest bin of the scan
      if (tag_v_ff && (rd_data_ff > best_ff)) begin
         best_ff <= rd_data_ff;
         bi_ff   <= tag_i_ff;
         bj_ff   <= tag_j_ff;
      end
   end

   // Peak centre and result beat
   assign cx_prod = 39'({bi_ff, 1'b1}) * 39'(bin_width_x_ff);
   assign cy_prod = 39'({bj_ff, 1'b1}) * 39'(bin_width_y_ff);
   assign cx_full = 40'(origin_x_ff) + signed'({2'b0, cx_prod[38:1]});
   assign cy_full = 40'(origin_y_ff) + signed'({2'b0, cy_prod[38:1]});

   always_comb begin
      rsp_next = '0;
      case (cmd_ff)
         CMD_SPLAT: rsp_next.bins_updated = count_ff;
         CMD_REPORT: begin
            rsp_next.peak_ix      = 6'(bi_ff);
            rsp_next.peak_iy      = 6'(bj_ff);
            rsp_next.peak_content = best_ff;
            rsp_next.peak_x       = sat32(cx_full);
            rsp_next.peak_y       = sat32(cy_full);
         end
         default: ;
      endcase
   end

   // Memory port selection
   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = sweep_ff;
      mem_wdata = '0;
      if (state_ff == ST_INIT || state_ff == ST_SWEEP) begin
         mem_we = 1'b1;
      end else if (state_ff == ST_WRITE) begin
         mem_we    = 1'b1;
         mem_waddr = addr_ff;
         mem_wdata = bin_sum[32] ? 32'hFFFF_FFFF : bin_sum[31:0];
      end
   end
   assign mem_re = (state_ff == ST_SQUARE) || (state_ff == ST_SCAN);

   // Bin store: one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (mem_we) bin_mem[mem_waddr] <= mem_wdata;
      if (mem_re) rd_data_ff <= bin_mem[bin_addr];
   end

   assign div_req.start    = div_go_ff;
   assign div_req.dividend = div_num_ff;
   assign div_req.divisor  = div_den_ff;

   ghsp_divider u_divider (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   assign busy       = (state_ff != ST_IDLE);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_item   = rsp_item_ff;

   // A result beat only follows the response state
   a_rsp_follows_resp: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe_ff |-> $past(state_ff == ST_RESP))
      else $error("result beat without response state");

   // A splat write never lowers a bin
   a_write_monotonic: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WRITE) |-> (mem_wdata >= rd_data_ff))
      else $error("bin decreased by splat");

   // Divider completion only arrives while a division is awaited
   a_div_done_waited: assert property (@(posedge clock) disable iff (reset)
      div_rsp.done |-> (state_ff == ST_WIN_DIV || state_ff == ST_COL_DIV
                        || state_ff == ST_ROW_DIV || state_ff == ST_WT_DIV))
      else $error("divider result not awaited");

   // Peak scan stays inside the bins in use
   a_scan_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> ((i_ff < nx) && (j_ff < ny)))
      else $error("scan outside used bins");

   // Bins of one splat never exceed the store
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WRITE) |=> (count_ff <= 13'(BIN_DEPTH)))
      else $error("splat bin count overflow");

endmodule

// ===== test/ghsp_checker.sv =====
// Scoreboard for the Gaussian splat histogram: watches the command, result and
// register ports, predicts each result beat and compares it. Depends on ghsp_pkg.
module ghsp_checker (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic                           busy,
   input  ghsp_pkg::req_item_type         req_item,
   input  logic                           rsp_strobe,
   input  ghsp_pkg::rsp_item_type         rsp_item,
   input  logic                           csr_we,
   input  logic [ghsp_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [31:0]                    csr_wdata,
   output int                             errors,
   output int                             pending
);
   timeunit 1ns;
   timeprecision 1ps;
   import ghsp_pkg::*;

   localparam longint unsigned Q32_ONE = 64'd1 << 32;
   localparam longint unsigned K_LIMIT = 64'd16 << 16;

   longint unsigned weight_tab [EXP_TABLE_DEPTH];
   logic [31:0]     hist [BIN_DEPTH];
   longint          org_x, org_y, bw_x, bw_y;
   longint unsigned cnt_x, cnt_y;
   rsp_item_type    expected_q [$];

   // Weight table: series for the step ratio, then rounded repeated products
   initial begin
      longint unsigned step, term, plus, minus, ratio;
      step  = (64'd16 << 32) / EXP_TABLE_DEPTH;
      term  = Q32_ONE;
      plus  = Q32_ONE;
      minus = 0;
      for (int k = 1; k <= 24; k++) begin
         term = (term * step) / k;
         if (k % 2 == 1) minus += term;
         else plus += term;
      end
      ratio = plus - minus;
      weight_tab[0] = Q32_ONE;
      for (int n = 1; n < EXP_TABLE_DEPTH; n++)
         weight_tab[n] = (weight_tab[n-1] * ratio + (64'd1 << 31)) >> 32;
   end

   function automatic longint used_bins(longint unsigned v, longint unsigned lim);
      if (v == 0) return 1;
      return (v > lim) ? lim : v;
   endfunction

   function automatic longint unsigned sigmas(longint num, longint unsigned sig);
      longint unsigned mag, q;
      mag = (num < 0) ? -num : num;
      q   = (mag * 65536) / (2 * sig);
      return (q > K_LIMIT) ? K_LIMIT : q;
   endfunction

   function automatic logic [31:0] clamp_s32(longint v);
      if (v > 64'sd2147483647) v = 64'sd2147483647;
      if (v < -64'sd2147483648) v = -64'sd2147483648;
      return v[31:0];
   endfunction

   // Window of bins visited along one axis, truncated toward zero and clamped
   function automatic void span(input longint d, input longint sig, input longint w,
                                input longint n, output longint lo, output longint hi);
      lo = (2 * (d - 4 * sig) - w) / (2 * w);
      hi = (2 * (d + 4 * sig) + w) / (2 * w);
      if (lo < 0) lo = 0;
      if (hi > n) hi = n;
   endfunction

   function automatic rsp_item_type apply_command(req_item_type it);
      rsp_item_type    r;
      longint          dx, dy, sx, sy, nx, ny, xl, xh, yl, yh, idx;
      longint unsigned kx, ky, e, n, w, sum, count, best, bi, bj;
      r  = '0;
      nx = used_bins(cnt_x, MAX_BINS_X);
      ny = used_bins(cnt_y, MAX_BINS_Y);
      case (it.command)
         CMD_SPLAT: begin
            dx = longint'(it.point_x) - org_x;
            dy = longint'(it.point_y) - org_y;
            sx = (it.spread_x == 0) ? 1 : it.spread_x;
            sy = (it.spread_y == 0) ? 1 : it.spread_y;
            span(dx, sx, bw_x, nx, xl, xh);
            span(dy, sy, bw_y, ny, yl, yh);
            count = 0;
            for (longint i = xl; i < xh; i++) begin
               kx = sigmas(2 * dx - (2 * i + 1) * bw_x, sx);
               for (longint j = yl; j < yh; j++) begin
                  ky  = sigmas(2 * dy - (2 * j + 1) * bw_y, sy);
                  e   = (kx * kx + ky * ky) >> 1;
                  n   = (e * EXP_TABLE_DEPTH) / (64'd16 << 32);
                  w   = 0;
                  if (n < EXP_TABLE_DEPTH)
                     w = (weight_tab[n] * 65536) / (sx * sy);
                  if (w > 64'hFFFF_FFFF) w = 64'hFFFF_FFFF;
                  idx = i + j * nx;
                  sum = hist[idx] + w;
                  hist[idx] = (sum > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : sum[31:0];
                  count++;
               end
            end
            r.bins_updated = count[12:0];
         end
         CMD_CLEAR: begin
            foreach (hist[k]) hist[k] = '0;
         end
         CMD_REPORT: begin
            best = 0; bi = 0; bj = 0;
            for (longint i = 0; i < nx; i++)
               for (longint j = 0; j < ny; j++)
                  if (hist[i + j * nx] > best) begin
                     best = hist[i + j * nx]; bi = i; bj = j;
                  end
            r.peak_ix      = bi[5:0];
            r.peak_iy      = bj[5:0];
            r.peak_content = best[31:0];
            r.peak_x       = clamp_s32(org_x + longint'(((2 * bi + 1) * bw_x) >> 1));
            r.peak_y       = clamp_s32(org_y + longint'(((2 * bj + 1) * bw_y) >> 1));
         end
         default: ;
      endcase
      return r;
   endfunction

   // Track registers and commands, compare every result beat in order
   always @(posedge clock) begin
      rsp_item_type want;
      if (reset) begin
         org_x = 0; org_y = 0; bw_x = 65536; bw_y = 65536; cnt_x = 64; cnt_y = 64;
         foreach (hist[k]) hist[k] = '0;
         expected_q.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_ORIGIN_X:    org_x = longint'(signed'(csr_wdata));
               CSR_ORIGIN_Y:    org_y = longint'(signed'(csr_wdata));
               CSR_BIN_WIDTH_X: bw_x  = (csr_wdata[30:0] == 0) ? 1 : csr_wdata[30:0];
               CSR_BIN_WIDTH_Y: bw_y  = (csr_wdata[30:0] == 0) ? 1 : csr_wdata[30:0];
               CSR_BINS_X:      cnt_x = csr_wdata[6:0];
               CSR_BINS_Y:      cnt_y = csr_wdata[6:0];
               default: ;
            endcase
         end
         if (rsp_strobe) begin
            if (expected_q.size() == 0) begin
               $error("result beat with nothing expected");
               errors++;
            end else begin
               want = expected_q.pop_front();
               if (rsp_item.bins_updated !== want.bins_updated) begin
                  $error("bins_updated: expected %0d, got %0d",
                         want.bins_updated, rsp_item.bins_updated);
                  errors++;
               end
               if (rsp_item.peak_ix !== want.peak_ix) begin
                  $error("peak_ix: expected %0d, got %0d", want.peak_ix, rsp_item.peak_ix);
                  errors++;
               end
               if (rsp_item.peak_iy !== want.peak_iy) begin
                  $error("peak_iy: expected %0d, got %0d", want.peak_iy, rsp_item.peak_iy);
                  errors++;
               end
               if (rsp_item.peak_content !== want.peak_content) begin
                  $error("peak_content: expected %h, got %h",
                         want.peak_content, rsp_item.peak_content);
                  errors++;
               end
               if (rsp_item.peak_x !== want.peak_x) begin
                  $error("peak_x: expected %h, got %h", want.peak_x, rsp_item.peak_x);
                  errors++;
               end
               if (rsp_item.peak_y !== want.peak_y) begin
                  $error("peak_y: expected %h, got %h", want.peak_y, rsp_item.peak_y);
                  errors++;
               end
            end
         end
         if (start && !busy) expected_q.insert(expected_q.size(), apply_command(req_item));
      end
      pending <= expected_q.size();
   end

   initial begin
      errors  = 0;
      pending = 0;
   end

endmodule

// ===== test/tb.sv =====
// Top of the histogram testbench: clock, reset, command and register stimulus,
// and the verdict. Depends on ghsp_pkg, the block and ghsp_checker.
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import ghsp_pkg::*;

   localparam longint CYCLE_LIMIT = 40_000_000;

   logic                 clock = 0;
   logic                 reset = 1;
   logic                 start = 0;
   logic                 busy;
   req_item_type         req_item = '0;
   logic                 rsp_strobe;
   rsp_item_type         rsp_item;
   logic                 csr_we = 0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [31:0]          csr_wdata = '0;
   int                   errors, pending;
   longint               cycles = 0;
   int                   burst_left = 1;
   int                   sent = 0;

   // Stimulus-side copy of the geometry, used to aim points at the area
   longint ox, oy, wx, wy, nx, ny;

   always #5 clock = ~clock;

   gaussian_histogram_splat_peak dut (.*);

   ghsp_checker chk (.*);

   // Hard stop on a hung run
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end
   end

   // Hold a command beat until taken, then either carry on the burst or pause
   task automatic issue(req_item_type it);
      start    <= 1;
      req_item <= it;
      do @(posedge clock); while (busy);
      sent++;
      burst_left--;
      if (burst_left <= 0) begin
         start <= 0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
         burst_left = $urandom_range(1, 12);
      end
   endtask

   // Drop start and wait until every expected result has come back
   task automatic drain();
      start <= 0;
      do @(posedge clock); while (pending != 0 || busy);
      repeat (10) @(posedge clock);
   endtask

   // Write all six registers while idle
   task automatic configure(logic [31:0] v0, logic [31:0] v1, logic [31:0] v2,
                            logic [31:0] v3, logic [31:0] v4, logic [31:0] v5);
      logic [31:0] vals [6];
      vals = '{v0, v1, v2, v3, v4, v5};
      drain();
      for (int i = 0; i < 6; i++) begin
         csr_we    <= 1;
         csr_index <= CSR_IDX_W'(i);
         csr_wdata <= vals[i];
         @(posedge clock);
      end
      csr_we <= 0;
      ox = longint'(signed'(v0));
      oy = longint'(signed'(v1));
      wx = (v2[30:0] == 0) ? 1 : v2[30:0];
      wy = (v3[30:0] == 0) ? 1 : v3[30:0];
      nx = (v4[6:0] == 0) ? 1 : (v4[6:0] > 64 ? 64 : v4[6:0]);
      ny = (v5[6:0] == 0) ? 1 : (v5[6:0] > 64 ? 64 : v5[6:0]);
   endtask

   function automatic req_item_type make(logic [1:0] c, logic [31:0] x, logic [31:0] y,
                                         logic [30:0] sx, logic [30:0] sy);
      req_item_type it;
      it.command  = c;
      it.point_x  = x;
      it.point_y  = y;
      it.spread_x = sx;
      it.spread_y = sy;
      return it;
   endfunction

   function automatic logic [31:0] aim(longint org, longint w, longint n);
      longint p;
      if ($urandom_range(0, 9) == 0) return $urandom;
      p = org + longint'($urandom_range(0, 1000)) * (n * w + 2 * w) / 1000 - w;
      if (p > 64'sd2147483647) p = 64'sd2147483647;
      if (p < -64'sd2147483648) p = -64'sd2147483648;
      return p[31:0];
   endfunction

   // Sigma mostly a fraction of the bin width; wide ones only on small grids
   function automatic logic [30:0] spread(longint w, bit wide_ok);
      longint s;
      int     pick;
      pick = $urandom_range(0, 19);
      if (pick == 0) return '0;
      if (pick == 1 && wide_ok) return 31'($urandom);
      if (pick == 2) return 31'($urandom_range(1, 8));
      s = (w * $urandom_range(1, 12)) / 16;
      if (s < 1) s = 1;
      if (s > 64'h7FFF_FFFF) s = 64'h7FFF_FFFF;
      return s[30:0];
   endfunction

   function automatic req_item_type random_item(bit wide_ok);
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 3)
         return make(CMD_CLEAR, $urandom, $urandom, 31'($urandom), 31'($urandom));
      if (pick < 6)
         return make(CMD_NONE, $urandom, $urandom, 31'($urandom), 31'($urandom));
      if (pick < 18)
         return make(CMD_REPORT, $urandom, $urandom, 31'($urandom), 31'($urandom));
      return make(CMD_SPLAT, aim(ox, wx, nx), aim(oy, wy, ny),
                  spread(wx, wide_ok), spread(wy, wide_ok));
   endfunction

   initial begin
      int n_phase;
      repeat (7) @(posedge clock);
      reset <= 0;
      ox = 0; oy = 0; wx = 65536; wy = 65536; nx = 64; ny = 64;

      // Directed: empty report, unused command, extreme points and sigmas
      issue(make(CMD_REPORT, '0, '0, '0, '0));
      issue(make(CMD_NONE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, '1, '1));
      issue(make(CMD_SPLAT, 32'h0000_8000, 32'h0000_8000, 31'd1, 31'd1));
      issue(make(CMD_SPLAT, 32'h0000_8000, 32'h0000_8000, 31'd1, 31'd1));
      issue(make(CMD_SPLAT, 32'h0020_0000, 32'h0010_0000, '0, '0));
      issue(make(CMD_SPLAT, 32'h8000_0000, 32'h8000_0000, 31'd65536, 31'd65536));
      issue(make(CMD_SPLAT, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 31'd65536, 31'd65536));
      issue(make(CMD_SPLAT, 32'h003F_8000, 32'h003F_8000, 31'd98304, 31'd32768));
      issue(make(CMD_REPORT, '0, '0, '0, '0));
      issue(make(CMD_SPLAT, 32'h0020_0000, 32'h0020_0000, 31'h7FFF_FFFF, 31'h7FFF_FFFF));
      issue(make(CMD_REPORT, '0, '0, '0, '0));
      issue(make(CMD_CLEAR, '0, '0, '0, '0));
      issue(make(CMD_REPORT, '0, '0, '0, '0));

      // Extreme geometry: zero widths and counts, then the widest and the top corner
      configure(32'h8000_0000, 32'h7FFF_FFFF, '0, '0, '0, '0);
      issue(make(CMD_SPLAT, 32'h8000_0000, 32'h7FFF_FFFF, 31'd1, 31'd1));
      issue(make(CMD_REPORT, '0, '0, '0, '0));
      configure(32'h7FFF_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF,
                32'hFFFF_FF7F, 32'd3);
      issue(make(CMD_SPLAT, 32'h7FFF_FFFF, 32'h8000_0000, '1, 31'd100));
      issue(make(CMD_REPORT, '0, '0, '0, '0));
      issue(make(CMD_CLEAR, '0, '0, '0, '0));

      // Random phases, each under a fresh geometry
      n_phase = 0;
      while (sent < 1800) begin
         if (n_phase % 6 == 5)
            configure($urandom_range(0, 1) ? $urandom : 32'(-$urandom_range(0, 1 << 22)),
                      $urandom, 32'($urandom_range(1 << 12, 1 << 18)),
                      32'($urandom_range(1 << 12, 1 << 18)), 32'd64, 32'd64);
         else
            configure($urandom_range(0, 3) == 0 ? $urandom : 32'($urandom_range(0, 1 << 20)),
                      $urandom_range(0, 3) == 0 ? $urandom : 32'(-$urandom_range(0, 1 << 20)),
                      $urandom_range(0, 4) == 0 ? $urandom : $urandom_range(1, 1 << 19),
                      $urandom_range(0, 4) == 0 ? $urandom : $urandom_range(1, 1 << 19),
                      32'($urandom_range(1, 7)) | ($urandom & 32'hFFFF_FF80),
                      32'($urandom_range(1, 7)));
         repeat ($urandom_range(60, 160))
            issue(random_item(nx * ny <= 64));
         n_phase++;
      end

      start <= 0;
      do @(posedge clock); while (pending != 0);
      repeat (20) @(posedge clock);
      $display("Ran %0d commands over %0d geometries: splats, clears, reports, unused code.",
               sent, n_phase + 3);
      if (errors == 0) $display("end of test: clean");
      else $display("end of test: mismatches");
      $finish;
   end

endmodule

// ===== filelist.f =====
hw/rtl/ghsp_pkg.sv
hw/rtl/ghsp_divider.sv
hw/rtl/gaussian_histogram_splat_peak.sv
test/ghsp_checker.sv
test/tb.sv
